[hw/rtl/knc_pkg.sv]
`timescale 1ns / 1ps

package knc_pkg;

  localparam int CAPACITY     = 16;
  localparam int COORD_BITS   = 16;
  localparam int ID_BITS      = 16;
  localparam int DIST_BITS    = 2 * COORD_BITS + 2;
  localparam int SQ_BITS      = 2 * COORD_BITS;
  localparam int CNT_BITS     = $clog2(CAPACITY + 1);
  localparam int IDX_BITS     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int KLIM_BITS    = 5;
  localparam int CFG_IDX_BITS = 3;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_CENTER_X  = 3'd0,
    CFG_CENTER_Y  = 3'd1,
    CFG_CENTER_Z  = 3'd2,
    CFG_RADIUS_SQ = 3'd3,
    CFG_K_LIMIT   = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIST,
    ST_UPD,
    ST_EMIT,
    ST_ROT
  } state_t;

  typedef struct packed {
    logic [DIST_BITS-1:0] dist_sq;
    logic [ID_BITS-1:0]   id;
  } entry_t;

  typedef struct packed {
    logic   ins;
    logic   rot;
    logic   below_n;
    logic   at_n;
    entry_t item;
  } cell_ctl_t;

endpackage

[hw/rtl/knc_dist.sv]
`timescale 1ns / 1ps

module knc_dist (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic signed [knc_pkg::COORD_BITS-1:0] px,
  input  logic signed [knc_pkg::COORD_BITS-1:0] py,
  input  logic signed [knc_pkg::COORD_BITS-1:0] pz,
  input  logic signed [knc_pkg::COORD_BITS-1:0] cx,
  input  logic signed [knc_pkg::COORD_BITS-1:0] cy,
  input  logic signed [knc_pkg::COORD_BITS-1:0] cz,
  output logic                                 done,
  output logic [knc_pkg::DIST_BITS-1:0]        dist_sq
);
  import knc_pkg::*;

  logic signed [COORD_BITS:0]     dx_r, dy_r, dz_r;
  logic signed [2*COORD_BITS+1:0] prod_x, prod_y, prod_z;
  logic [SQ_BITS-1:0]             sqx_r, sqy_r, sqz_r;
  logic [DIST_BITS-1:0]           dist_r;
  logic [2:0]                     vld_r;

  assign prod_x = dx_r * dx_r;
  assign prod_y = dy_r * dy_r;
  assign prod_z = dz_r * dz_r;

  always_ff @(posedge clk) begin
    if (start) begin
      dx_r <= {px[COORD_BITS-1], px} - {cx[COORD_BITS-1], cx};
      dy_r <= {py[COORD_BITS-1], py} - {cy[COORD_BITS-1], cy};
      dz_r <= {pz[COORD_BITS-1], pz} - {cz[COORD_BITS-1], cz};
    end
    sqx_r  <= prod_x[SQ_BITS-1:0];
    sqy_r  <= prod_y[SQ_BITS-1:0];
    sqz_r  <= prod_z[SQ_BITS-1:0];
    dist_r <= DIST_BITS'(sqx_r) + DIST_BITS'(sqy_r) + DIST_BITS'(sqz_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[1:0], start};
    end
  end

  assign done    = vld_r[2];
  assign dist_sq = dist_r;

endmodule

[hw/rtl/knc_cell.sv]
`timescale 1ns / 1ps

module knc_cell (
  input  logic                clk,
  input  knc_pkg::cell_ctl_t  ctl,
  input  knc_pkg::entry_t     lower_i,
  input  knc_pkg::entry_t     upper_i,
  input  logic                prev_gt_i,
  output logic                gt_o,
  output knc_pkg::entry_t     entry_o
);
  import knc_pkg::*;

  entry_t entry_r, entry_nxt;

  // A kept entry strictly farther than the new point moves up one place.
  assign gt_o = ctl.below_n && (entry_r.dist_sq > ctl.item.dist_sq);

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.rot) begin
      entry_nxt = upper_i;
    end else if (ctl.ins) begin
      if (prev_gt_i) begin
        entry_nxt = lower_i;
      end else if (gt_o || ctl.at_n) begin
        entry_nxt = ctl.item;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_o = entry_r;

endmodule

[hw/rtl/k_nearest_candidate_buffer.sv]
`timescale 1ns / 1ps
// Insert: knc_dist computes the distance, then ST_UPD updates the cells and ST_EMIT loads the result;
// no new request is taken until the block is back in ST_IDLE. Readout: the cell chain rotates once
// through all CAPACITY cells, one result per cycle for each kept entry while the output is not stalled;
// an empty list gives a single result with no entry. Clear: the result is loaded in ST_EMIT.
// Reset (synchronous, active low) empties the list and restores the register defaults;
// the stored entries themselves are not cleared.
module k_nearest_candidate_buffer (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [knc_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [knc_pkg::DIST_BITS-1:0]         cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [1:0]                            in_opcode,
  input  logic signed [knc_pkg::COORD_BITS-1:0] in_point_x,
  input  logic signed [knc_pkg::COORD_BITS-1:0] in_point_y,
  input  logic signed [knc_pkg::COORD_BITS-1:0] in_point_z,
  input  logic [knc_pkg::ID_BITS-1:0]           in_point_id,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_accepted,
  output logic                                  out_entry_valid,
  output logic [knc_pkg::ID_BITS-1:0]           out_entry_id,
  output logic [knc_pkg::DIST_BITS-1:0]         out_entry_dist_sq,
  output logic [knc_pkg::DIST_BITS-1:0]         out_max_dist_sq,
  output logic [knc_pkg::CNT_BITS-1:0]          out_count,
  output logic                                  out_last
);
  import knc_pkg::*;

  logic signed [COORD_BITS-1:0] cx_r, cy_r, cz_r;
  logic [DIST_BITS-1:0]         radius_r;
  logic [KLIM_BITS-1:0]         klim_r;

  state_t               state_r, state_nxt;
  logic [CNT_BITS-1:0]  count_r, count_nxt;
  logic                 accept_r, accept_nxt;
  logic [IDX_BITS-1:0]  n_r, n_nxt;
  logic [IDX_BITS-1:0]  rc_r, rc_nxt;
  logic [DIST_BITS-1:0] bound_r, bound_nxt;
  logic [ID_BITS-1:0]   pid_r;

  logic                 dist_start, dist_done;
  logic [DIST_BITS-1:0] pt_dist;
  logic                 ins_en, rot_en;

  logic [CNT_BITS-1:0]  eff_k, n_c;
  logic [IDX_BITS-1:0]  last_idx;
  entry_t               tail;
  logic                 full, ins_ok, out_free, emit_now;
  logic [DIST_BITS-1:0] bound_c;

  entry_t               cell_entry [CAPACITY];
  logic [CAPACITY-1:0]  cell_gt;
  entry_t               new_item;

  logic                 out_valid_r, out_load;
  logic                 acc_nxt, ev_nxt, last_nxt;
  logic [ID_BITS-1:0]   eid_nxt;
  logic [DIST_BITS-1:0] edist_nxt, max_nxt;
  logic [CNT_BITS-1:0]  cnt_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r     <= '0;
      cy_r     <= '0;
      cz_r     <= '0;
      radius_r <= '0;
      klim_r   <= KLIM_BITS'(CAPACITY);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_CENTER_X:  cx_r     <= cfg_data[COORD_BITS-1:0];
        CFG_CENTER_Y:  cy_r     <= cfg_data[COORD_BITS-1:0];
        CFG_CENTER_Z:  cz_r     <= cfg_data[COORD_BITS-1:0];
        CFG_RADIUS_SQ: radius_r <= cfg_data;
        CFG_K_LIMIT:   klim_r   <= cfg_data[KLIM_BITS-1:0];
        default: ;
      endcase
    end
  end

  knc_dist u_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (dist_start),
    .px      (in_point_x),
    .py      (in_point_y),
    .pz      (in_point_z),
    .cx      (cx_r),
    .cy      (cy_r),
    .cz      (cz_r),
    .done    (dist_done),
    .dist_sq (pt_dist)
  );

  always_ff @(posedge clk) begin
    if (dist_start) begin
      pid_r <= in_point_id;
    end
  end

  assign new_item = '{dist_sq: pt_dist, id: pid_r};

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_ctl_t ctl;
    entry_t    lower, upper;
    logic      prev_gt;

    assign ctl.ins     = ins_en;
    assign ctl.rot     = rot_en;
    assign ctl.below_n = CNT_BITS'(i) < CNT_BITS'(n_r);
    assign ctl.at_n    = IDX_BITS'(i) == n_r;
    assign ctl.item    = new_item;

    if (i == 0) begin : g_head
      assign lower   = new_item;
      assign prev_gt = 1'b0;
    end else begin : g_body
      assign lower   = cell_entry[i-1];
      assign prev_gt = cell_gt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_wrap
      assign upper = cell_entry[0];
    end else begin : g_next
      assign upper = cell_entry[i+1];
    end

    knc_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .lower_i   (lower),
      .upper_i   (upper),
      .prev_gt_i (prev_gt),
      .gt_o      (cell_gt[i]),
      .entry_o   (cell_entry[i])
    );
  end

  assign eff_k = ((klim_r == '0) || (32'(klim_r) > CAPACITY)) ? CNT_BITS'(CAPACITY)
                                                               : CNT_BITS'(klim_r);
  assign last_idx = IDX_BITS'(count_r - 1'b1);
  assign tail     = cell_entry[last_idx];
  assign full     = (count_r != '0) && (count_r >= eff_k);
  assign bound_c  = full ? tail.dist_sq : ((radius_r != '0) ? radius_r : '1);
  assign ins_ok   = !((radius_r != '0) && (pt_dist > radius_r)) &&
                    !(full && (pt_dist >= tail.dist_sq));
  assign n_c      = full ? (count_r - 1'b1) : count_r;

  assign out_free = !out_valid_r || !out_stall;
  assign emit_now = CNT_BITS'(rc_r) < count_r;
  assign in_stall = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      count_r  <= '0;
      accept_r <= 1'b0;
      n_r      <= '0;
      rc_r     <= '0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      accept_r <= accept_nxt;
      n_r      <= n_nxt;
      rc_r     <= rc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bound_r <= bound_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    accept_nxt = accept_r;
    n_nxt      = n_r;
    rc_nxt     = rc_r;
    bound_nxt  = bound_r;
    dist_start = 1'b0;
    ins_en     = 1'b0;
    rot_en     = 1'b0;
    out_load   = 1'b0;
    acc_nxt    = 1'b0;
    ev_nxt     = 1'b0;
    eid_nxt    = '0;
    edist_nxt  = '0;
    max_nxt    = bound_c;
    cnt_nxt    = count_r;
    last_nxt   = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          accept_nxt = 1'b0;
          unique case (in_opcode)
            OP_INSERT: begin
              dist_start = 1'b1;
              state_nxt  = ST_DIST;
            end
            OP_READ: begin
              bound_nxt = bound_c;
              rc_nxt    = '0;
              state_nxt = (count_r == '0) ? ST_EMIT : ST_ROT;
            end
            OP_CLEAR: begin
              count_nxt = '0;
              state_nxt = ST_EMIT;
            end
            default: ;
          endcase
        end
      end
      ST_DIST: begin
        if (dist_done) begin
          accept_nxt = ins_ok;
          n_nxt      = IDX_BITS'(n_c);
          state_nxt  = ST_UPD;
        end
      end
      ST_UPD: begin
        ins_en = accept_r;
        if (accept_r) begin
          count_nxt = CNT_BITS'(n_r) + 1'b1;
        end
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load  = 1'b1;
          acc_nxt   = accept_r;
          state_nxt = ST_IDLE;
        end
      end
      ST_ROT: begin
        if (emit_now && out_free) begin
          out_load  = 1'b1;
          ev_nxt    = 1'b1;
          eid_nxt   = cell_entry[0].id;
          edist_nxt = cell_entry[0].dist_sq;
          max_nxt   = bound_r;
          last_nxt  = (CNT_BITS'(rc_r) + 1'b1) == count_r;
        end
        if (!emit_now || out_free) begin
          rot_en = 1'b1;
          if (rc_r == IDX_BITS'(CAPACITY - 1)) begin
            state_nxt = ST_IDLE;
          end else begin
            rc_nxt = rc_r + 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_accepted      <= acc_nxt;
      out_entry_valid   <= ev_nxt;
      out_entry_id      <= eid_nxt;
      out_entry_dist_sq <= edist_nxt;
      out_max_dist_sq   <= max_nxt;
      out_count         <= cnt_nxt;
      out_last          <= last_nxt;
    end
  end

  assign out_valid = out_valid_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_BITS'(CAPACITY))
    else $error("Kept count exceeds the capacity.");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROT) |=> $stable(count_r))
    else $error("Kept count changed during a readout.");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_entry_valid) |-> (!out_accepted && (out_count != '0)))
    else $error("Readout result carries an insert flag or an empty count.");

endmodule
